### design/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared opcodes, status codes and controller/datapath interface structs for
// the indexed list insert/delete core.
// ----------------------------------------------------------------------------
package ilid_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 7;

	localparam logic [OP_W-1:0] OP_GET      = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the incoming command
		logic eval;      // range check, set up the move pointer, read for get
		logic shift;     // move one entry (or end the move)
		logic put;       // write the new value, bump the count
		logic load_out;  // load the result register
	} ilid_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ins_ok;
		logic del_ok;
		logic ins_op;    // latched opcode is one of the inserts
		logic more;      // move loop has another entry to move
	} ilid_stat_t;

endpackage

### design/ilid_ctrl.sv
// ----------------------------------------------------------------------------
// ilid_ctrl
// Command sequencer: accepts a command, steps the datapath through the check,
// the entry moves and an insert's value write, and hands the result out.
// ----------------------------------------------------------------------------
module ilid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ilid_pkg::ilid_stat_t stat,
	output ilid_pkg::ilid_cmd_t  cmd
);
	import ilid_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_PUT    = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.capture  = in_valid && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.ins_ok || stat.del_ok)
					state_d = S_SHIFT;
				else
					state_d = S_RESULT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (!stat.more)
					state_d = stat.ins_op ? S_PUT : S_RESULT;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> slot_free)
		else $error("result loaded over an untaken result");
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EVAL))
		else $error("accepted transfer not evaluated");
	a_put_after_ins: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> ($past(state_q) == S_SHIFT && stat.ins_op))
		else $error("value write outside an insert");
`endif

endmodule

### design/ilid_dp.sv
// ----------------------------------------------------------------------------
// ilid_dp
// List datapath: entry memory (one write, one registered read port), count,
// range checks, move pointer and result register.
// ----------------------------------------------------------------------------
module ilid_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ilid_pkg::ilid_cmd_t                cmd,
	output ilid_pkg::ilid_stat_t               stat,
	input  logic [ilid_pkg::OP_W-1:0]          opcode,
	input  logic [ilid_pkg::POS_W-1:0]         position,
	input  logic signed [ilid_pkg::DATA_W-1:0] data_in,
	output logic signed [ilid_pkg::DATA_W-1:0] read_value,
	output logic                               found,
	output logic [ilid_pkg::ST_W-1:0]          status,
	output logic [ilid_pkg::LEN_W-1:0]         length
);
	import ilid_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [DATA_W-1:0] mem [CAPACITY];

	logic [OP_W-1:0]          opcode_q;
	logic [POS_W-1:0]         position_q;
	logic signed [DATA_W-1:0] data_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] dst_q;
	logic [ST_W-1:0]  res_status_q;
	logic             res_found_q;

	logic [DATA_W-1:0] rdata_q;
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic signed [DATA_W-1:0] read_value_q;
	logic                     found_q;
	logic [ST_W-1:0]          status_q;
	logic [LEN_W-1:0]         length_q;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] eff_x;
	logic             is_get, is_ins, is_del;
	logic             range_err, full_err;
	logic [ST_W-1:0]  eval_status;
	logic             more;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	// ---- command decode and range checks
	always_comb begin
		is_get = (opcode_q == OP_GET);
		is_ins = (opcode_q == OP_INS_HEAD) || (opcode_q == OP_INS_TAIL) ||
			(opcode_q == OP_INS_POS);
		is_del = (opcode_q == OP_DELETE);
		pos_x  = CMP_W'(position_q);
		cnt_x  = CMP_W'(count_q);
		case (opcode_q)
			OP_INS_HEAD: eff_x = '0;
			OP_INS_TAIL: eff_x = cnt_x;
			default:     eff_x = pos_x;
		endcase
		if (is_ins)
			range_err = (eff_x > cnt_x);
		else if (is_get || is_del)
			range_err = (pos_x >= cnt_x);
		else
			range_err = 1'b1;
		full_err = is_ins && !range_err && (count_q == CNT_W'(CAPACITY));
		if (range_err)
			eval_status = ST_RANGE;
		else if (full_err)
			eval_status = ST_FULL;
		else
			eval_status = ST_DONE;
	end

	// insert walks the destination down to pos+1, delete walks it up to count-2
	always_comb begin
		if (is_ins)
			more = (dst_q > pos_q);
		else
			more = ({1'b0, dst_q} + 1'b1) < {1'b0, count_q};
	end

	always_comb begin
		stat        = '0;
		stat.ins_ok = is_ins && !range_err && !full_err;
		stat.del_ok = is_del && !range_err;
		stat.ins_op = is_ins;
		stat.more   = more;
	end

	// ---- memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(position_q);
		if (cmd.eval) begin
			rd_en   = is_get && !range_err;
			rd_addr = ADDR_W'(position_q);
		end else if (cmd.shift && more) begin
			rd_en   = 1'b1;
			rd_addr = is_ins ? ADDR_W'(dst_q - 1'b1) : ADDR_W'(dst_q + 1'b1);
		end
		wr_en   = wr_pend_s1 || cmd.put;
		wr_addr = wr_pend_s1 ? waddr_s1 : pos_q[ADDR_W-1:0];
		wr_data = wr_pend_s1 ? rdata_q : $unsigned(data_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// ---- command and working registers (payload)
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q   <= opcode;
			position_q <= position;
			data_q     <= data_in;
		end
		if (cmd.eval) begin
			res_status_q <= eval_status;
			res_found_q  <= is_get && !range_err;
			pos_q        <= CNT_W'(eff_x);
			dst_q        <= is_ins ? count_q : CNT_W'(eff_x);
		end else if (cmd.shift && more) begin
			dst_q <= is_ins ? (dst_q - 1'b1) : (dst_q + 1'b1);
		end
		if (cmd.shift)
			waddr_s1 <= ADDR_W'(dst_q);
		if (cmd.load_out) begin
			read_value_q <= res_found_q ? $signed(rdata_q) : '0;
			found_q      <= res_found_q;
			status_q     <= res_status_q;
			length_q     <= LEN_W'(count_q);
		end
	end

	// ---- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.shift && more;
			if (cmd.put)
				count_q <= count_q + 1'b1;
			else if (cmd.shift && !more && !is_ins)
				count_q <= count_q - 1'b1;
		end
	end

	assign read_value = read_value_q;
	assign found      = found_q;
	assign status     = status_q;
	assign length     = length_q;

`ifndef NO_ASSERTIONS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_pend_s1 && cmd.put))
		else $error("move write and value write in one cycle");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == CNT_W'($past(count_q) + 1'b1)) ||
		(count_q == CNT_W'($past(count_q) - 1'b1))))
		else $error("count changed by more than one");
`endif

endmodule

### design/indexed_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of up to CAPACITY signed 32-bit values with get, insert at
// head/tail/position and delete at position; one result per command.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A get, a rejected command or an unknown
// opcode goes from the check straight to the result. With p the target
// position, an insert moves the entries from p up by one, starting at the
// tail, then writes the value at p; a delete moves the entries after p down.
// The moves go through the entry memory one entry per cycle on its single
// read port and single write port. A finished result sits in the output
// register while the next command is taken; a command finishing before the
// previous result is taken waits for it. The entry memory needs no clearing
// after reset.
module indexed_list_insert_delete_core #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ilid_pkg::OP_W-1:0]          opcode,
	input  logic [ilid_pkg::POS_W-1:0]         position,
	input  logic signed [ilid_pkg::DATA_W-1:0] data_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ilid_pkg::DATA_W-1:0] read_value,
	output logic                               found,
	output logic [ilid_pkg::ST_W-1:0]          status,
	output logic [ilid_pkg::LEN_W-1:0]         length
);
	import ilid_pkg::*;

	ilid_cmd_t  cmd;
	ilid_stat_t stat;

	ilid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ilid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (opcode),
		.position   (position),
		.data_in    (data_in),
		.read_value (read_value),
		.found      (found),
		.status     (status),
		.length     (length)
	);

endmodule
